// ===== hdl/bmp_stream_to_rgb565_core_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros used by the BMP stream decoder checker
// ---------------------------------------------------------------------------
`ifndef BMP_STREAM_TO_RGB565_CORE_DEFINES_SVH
`define BMP_STREAM_TO_RGB565_CORE_DEFINES_SVH

// same-cycle implication, checked on the rising clock edge outside reset
`define BMP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked on the rising clock edge outside reset
`define BMP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication that is also checked while reset is high
`define BMP_ASSERT_ALWAYS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/bmp565_pkg.sv =====
// ---------------------------------------------------------------------------
// bmp565_pkg
// Word types, result kinds and header constants of the BMP stream decoder.
// ---------------------------------------------------------------------------
package bmp565_pkg;

   // header layout
   localparam int unsigned HEADER_BYTES = 54;
   localparam logic [5:0]  HDR_LAST_POS      = 6'(HEADER_BYTES - 1);
   localparam logic [5:0]  HDR_WIDTH_POS     = 6'd18;
   localparam logic [5:0]  HDR_HEIGHT_LO_POS = 6'd22;
   localparam logic [5:0]  HDR_HEIGHT_HI_POS = 6'd23;
   localparam logic [5:0]  HDR_DEPTH_POS     = 6'd28;

   // result kinds
   localparam logic [1:0] KIND_WINDOW = 2'd0;
   localparam logic [1:0] KIND_PIXEL  = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   // csr indexes
   localparam logic CSR_SCREEN_WIDTH  = 1'b0;
   localparam logic CSR_SCREEN_HEIGHT = 1'b1;

   localparam logic [9:0] SCREEN_WIDTH_RESET  = 10'd240;
   localparam logic [9:0] SCREEN_HEIGHT_RESET = 10'd320;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       file_start;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] pixel;
      logic [9:0]  x_start;
      logic [9:0]  y_start;
      logic [7:0]  image_width;
      logic [15:0] image_height;
      logic        last;
   } rsp_word_type;

endpackage

// ===== hdl/bmp_stream_to_rgb565_core.sv =====
// ---------------------------------------------------------------------------
// bmp_stream_to_rgb565_core
// Byte-serial BMP decoder: header capture, centred window setup, RGB565 out.
// ---------------------------------------------------------------------------
// Result words are registered; the skid entry holds one while rsp is stalled.
// Throughput: one byte per cycle unless stalled; the whole decode step sits
//   between request handshake and output register, backed by one skid entry.
// req_stall rises only while the skid entry is occupied.
// Reset (synchronous, active high): decoder state cleared, output empty,
//   screen size back to 240 x 320.
// ---------------------------------------------------------------------------
module bmp_stream_to_rgb565_core
   import bmp565_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // byte stream in
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_data,
   // result words out
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_data,
   // register writes
   input  logic         csr_wr_en,
   input  logic         csr_index,
   input  logic [9:0]   csr_wdata
);

   // screen size registers
   logic [9:0]  screen_width_ff,  screen_width_in;
   logic [9:0]  screen_height_ff, screen_height_in;

   // decoder state
   logic [5:0]  byte_offset_ff,  byte_offset_in;
   logic [7:0]  hdr_width_ff,    hdr_width_in;
   logic [15:0] hdr_height_ff,   hdr_height_in;
   logic [4:0]  bpp_ff,          bpp_in;
   logic [4:0]  byte_phase_ff,   byte_phase_in;
   logic [15:0] pixel_accum_ff,  pixel_accum_in;
   logic [23:0] pixel_count_ff,  pixel_count_in;
   logic [23:0] pixel_total_ff,  pixel_total_in;
   logic        finished_ff,     finished_in;

   // output register and skid entry
   logic         out_valid_ff,  out_valid_in;
   rsp_word_type out_word_ff,   out_word_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_word_type skid_word_ff,  skid_word_in;

   logic         accept;
   logic         take_out;
   logic         emit;
   rsp_word_type res;

   // state as seen by this byte: file_start wipes it first
   logic [5:0]  cur_offset;
   logic [7:0]  cur_width;
   logic [15:0] cur_height;
   logic [4:0]  cur_bpp;
   logic [4:0]  cur_phase;
   logic [15:0] cur_accum;
   logic [23:0] cur_count;
   logic [23:0] cur_total;
   logic        cur_finished;

   logic [7:0]  b;
   logic [4:0]  phase_next;
   logic [23:0] count_next;
   logic [15:0] accum_next;
   logic [23:0] area;
   logic [9:0]  x_centre, y_centre;
   logic [10:0] x_diff;
   logic [16:0] y_diff;

   assign accept    = req_valid && !req_stall;
   assign take_out  = out_valid_ff && !rsp_stall;
   assign req_stall = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_word_ff;

   assign b = req_data.data_byte;

   always_comb begin
      if (req_data.file_start) begin
         cur_offset   = '0;
         cur_width    = '0;
         cur_height   = '0;
         cur_bpp      = '0;
         cur_phase    = '0;
         cur_accum    = '0;
         cur_count    = '0;
         cur_total    = '0;
         cur_finished = 1'b0;
      end else begin
         cur_offset   = byte_offset_ff;
         cur_width    = hdr_width_ff;
         cur_height   = hdr_height_ff;
         cur_bpp      = bpp_ff;
         cur_phase    = byte_phase_ff;
         cur_accum    = pixel_accum_ff;
         cur_count    = pixel_count_ff;
         cur_total    = pixel_total_ff;
         cur_finished = finished_ff;
      end
   end

   // header sizes are final by the last header byte, so the window math
   // works on the stored values
   assign area   = 24'(cur_width * cur_height);
   assign x_diff = {1'b0, screen_width_ff} - {3'b0, cur_width};
   assign y_diff = {7'b0, screen_height_ff} - {1'b0, cur_height};
   assign x_centre = ({2'b0, cur_width} < screen_width_ff) ? x_diff[10:1] : '0;
   assign y_centre = (cur_height < {6'b0, screen_height_ff}) ? y_diff[10:1] : '0;

   // pixel assembly
   assign phase_next = cur_phase + 5'd1;
   assign count_next = cur_count + 24'd1;

   always_comb begin
      accum_next = cur_accum;
      case (cur_bpp)
         5'd2: begin
            // 555 little endian: widen green to six bits
            if (cur_phase == 5'd0)
               accum_next = {7'b0, b[7:5], 1'b0, b[4:0]};
            else if (cur_phase == 5'd1)
               accum_next = cur_accum + {b[6:0], 9'b0};
         end
         5'd3: begin
            // B, G, R byte order
            if (cur_phase == 5'd0)
               accum_next = {11'b0, b[7:3]};
            else if (cur_phase == 5'd1)
               accum_next = cur_accum + {5'b0, b[7:2], 5'b0};
            else if (cur_phase == 5'd2)
               accum_next = cur_accum + {b[7:3], 11'b0};
         end
         default: accum_next = cur_accum;
      endcase
   end

   // decode step
   always_comb begin
      byte_offset_in = byte_offset_ff;
      hdr_width_in   = hdr_width_ff;
      hdr_height_in  = hdr_height_ff;
      bpp_in         = bpp_ff;
      byte_phase_in  = byte_phase_ff;
      pixel_accum_in = pixel_accum_ff;
      pixel_count_in = pixel_count_ff;
      pixel_total_in = pixel_total_ff;
      finished_in    = finished_ff;
      emit           = 1'b0;
      res            = '0;
      res.image_width  = cur_width;
      res.image_height = cur_height;

      if (accept) begin
         byte_offset_in = cur_offset;
         hdr_width_in   = cur_width;
         hdr_height_in  = cur_height;
         bpp_in         = cur_bpp;
         byte_phase_in  = cur_phase;
         pixel_accum_in = cur_accum;
         pixel_count_in = cur_count;
         pixel_total_in = cur_total;
         finished_in    = cur_finished;

         if (!cur_finished) begin
            if (cur_offset < 6'(HEADER_BYTES)) begin
               case (cur_offset)
                  HDR_WIDTH_POS:     hdr_width_in = b;
                  HDR_HEIGHT_LO_POS: hdr_height_in = {cur_height[15:8], b};
                  HDR_HEIGHT_HI_POS: hdr_height_in = {b, cur_height[7:0]};
                  HDR_DEPTH_POS:     bpp_in = b[7:3];
                  default:           hdr_width_in = cur_width;
               endcase
               byte_offset_in = cur_offset + 6'd1;
               if (cur_offset == HDR_LAST_POS) begin
                  pixel_total_in = area;
                  pixel_count_in = '0;
                  pixel_accum_in = '0;
                  byte_phase_in  = '0;
                  emit           = 1'b1;
                  if (cur_width == '0 || cur_height == '0 || cur_bpp == '0) begin
                     // bad header: stop until the next file
                     finished_in = 1'b1;
                     res.kind    = KIND_ERROR;
                  end else begin
                     res.kind    = KIND_WINDOW;
                     res.x_start = x_centre;
                     res.y_start = y_centre;
                  end
               end
            end else begin
               if (phase_next == cur_bpp) begin
                  emit           = 1'b1;
                  pixel_count_in = count_next;
                  pixel_accum_in = '0;
                  byte_phase_in  = '0;
                  res.kind       = KIND_PIXEL;
                  res.pixel      = accum_next;
                  res.last       = (count_next == cur_total);
                  if (count_next == cur_total)
                     finished_in = 1'b1;
               end else begin
                  pixel_accum_in = accum_next;
                  byte_phase_in  = phase_next;
               end
            end
         end
      end
   end

   // output register with one skid entry behind it
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_word_in   = out_word_ff;
      skid_valid_in = skid_valid_ff;
      skid_word_in  = skid_word_ff;
      if (!out_valid_ff || take_out) begin
         if (skid_valid_ff) begin
            // no byte is taken while the skid entry is full
            out_valid_in  = 1'b1;
            out_word_in   = skid_word_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = emit;
            out_word_in  = res;
         end
      end else if (emit) begin
         skid_valid_in = 1'b1;
         skid_word_in  = res;
      end
   end

   // register writes
   always_comb begin
      screen_width_in  = screen_width_ff;
      screen_height_in = screen_height_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_SCREEN_WIDTH:  screen_width_in  = csr_wdata;
            CSR_SCREEN_HEIGHT: screen_height_in = csr_wdata;
            default:           screen_width_in  = screen_width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= SCREEN_WIDTH_RESET;
         screen_height_ff <= SCREEN_HEIGHT_RESET;
         byte_offset_ff   <= '0;
         hdr_width_ff     <= '0;
         hdr_height_ff    <= '0;
         bpp_ff           <= '0;
         byte_phase_ff    <= '0;
         pixel_accum_ff   <= '0;
         pixel_count_ff   <= '0;
         pixel_total_ff   <= '0;
         finished_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
         skid_valid_ff    <= 1'b0;
      end else begin
         screen_width_ff  <= screen_width_in;
         screen_height_ff <= screen_height_in;
         byte_offset_ff   <= byte_offset_in;
         hdr_width_ff     <= hdr_width_in;
         hdr_height_ff    <= hdr_height_in;
         bpp_ff           <= bpp_in;
         byte_phase_ff    <= byte_phase_in;
         pixel_accum_ff   <= pixel_accum_in;
         pixel_count_ff   <= pixel_count_in;
         pixel_total_ff   <= pixel_total_in;
         finished_ff      <= finished_in;
         out_valid_ff     <= out_valid_in;
         skid_valid_ff    <= skid_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      out_word_ff  <= out_word_in;
      skid_word_ff <= skid_word_in;
   end

endmodule

// ===== hdl/bmp565_checker.sv =====
// ---------------------------------------------------------------------------
// bmp565_checker
// Port-level checks on the BMP stream decoder, bound to bmp_stream_to_rgb565_core.
// ---------------------------------------------------------------------------
`include "bmp_stream_to_rgb565_core_defines.svh"

module bmp565_checker
   import bmp565_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_word_type rsp_data
);

   // stalled word holds
   `BMP_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "rsp word changed under stall")

   // last only on a pixel word
   `BMP_ASSERT_NOW(a_last_pixel, rsp_valid && rsp_data.last, rsp_data.kind == KIND_PIXEL, "last flag on non-pixel word")

   // non-pixel words carry no color
   `BMP_ASSERT_NOW(a_no_color, rsp_valid && rsp_data.kind != KIND_PIXEL, rsp_data.pixel == 16'd0 && !rsp_data.last, "color on non-pixel word")

   // reset empties the output side
   `BMP_ASSERT_ALWAYS(a_reset_empty, reset, !rsp_valid && !req_stall, "output not empty after reset")

endmodule

bind bmp_stream_to_rgb565_core bmp565_checker u_bmp565_checker (.*);
